// ===== rtl/tc_pkg.sv =====
// ----------------------------------------------------------------------------
// tc_pkg: shared definitions for the triangle counter
// Field widths, reset values, request codes, sequencer states and the
// control group passed from the sequencer to the adjacency matrix.
// ----------------------------------------------------------------------------
package tc_pkg;

	// Field widths fixed by the request and result formats
	localparam int NODE_W  = 6;
	localparam int NCFG_W  = 7;
	localparam int COUNT_W = 16;

	// Defaults and limits
	localparam int MAX_NODES_DEF = 64;
	localparam int ROW_LIMIT     = 64;   // endpoints are six bits wide
	localparam logic [NCFG_W-1:0]  NODE_COUNT_RST = 7'd64;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;

	// Request codes
	typedef enum logic {
		OP_EDGE  = 1'b0,
		OP_COUNT = 1'b1
	} op_t;

	// Count sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} tc_state_t;

	// Sequencer to matrix control
	typedef struct packed {
		logic rd_en;   // read a row pair for the scan
		logic clear;   // drop the whole graph
	} tc_ctl_t;

endpackage

// ===== rtl/tc_matrix.sv =====
// ----------------------------------------------------------------------------
// tc_matrix: adjacency storage
// Upper-triangle bit matrix in a two-read, one-write memory. Edge requests
// do a read-modify-write on one row with forwarding for back-to-back hits;
// per-row valid bits clear the whole matrix without a clearing pass.
// ----------------------------------------------------------------------------
module tc_matrix #(
	parameter int W  = 64,
	parameter int IW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            edge_req,
	input  logic [IW-1:0]   edge_row,
	input  logic [IW-1:0]   edge_col,
	input  tc_pkg::tc_ctl_t ctl,
	input  logic [IW-1:0]   rd_i,
	input  logic [IW-1:0]   rd_j,
	output logic [W-1:0]    row_i_data,
	output logic [W-1:0]    row_j_data
);

	logic [W-1:0]  mem_q [W];
	logic [W-1:0]  valid_q;
	logic [W-1:0]  ra_q, rb_q;
	logic          va_q, vb_q;
	logic [W-1:0]  wdata_q;
	logic          wr_s1, fwd_s1;
	logic [IW-1:0] row_s1, col_s1;
	logic [IW-1:0] addr_a;
	logic          port_a_en;
	logic [W-1:0]  base, wr_data;

	// Steer port A between edge updates and the scan
	assign addr_a    = edge_req ? edge_row : rd_i;
	assign port_a_en = edge_req | ctl.rd_en;

	// Merge the new bit into the current row, forwarding the last write
	always_comb begin
		if (fwd_s1) begin
			base = wdata_q;
		end else begin
			base = va_q ? ra_q : '0;
		end
		wr_data = base | ({{(W-1){1'b0}}, 1'b1} << col_s1);
	end

	assign row_i_data = va_q ? ra_q : '0;
	assign row_j_data = vb_q ? rb_q : '0;

	// Memory array: registered reads, one write port
	always_ff @(posedge clk) begin
		if (port_a_en) begin
			ra_q <= mem_q[addr_a];
			va_q <= valid_q[addr_a];
		end
		if (ctl.rd_en) begin
			rb_q <= mem_q[rd_j];
			vb_q <= valid_q[rd_j];
		end
		if (wr_s1) begin
			mem_q[row_s1] <= wr_data;
			wdata_q       <= wr_data;
		end
	end

	// Update payload
	always_ff @(posedge clk) begin
		if (edge_req) begin
			row_s1 <= edge_row;
			col_s1 <= edge_col;
		end
	end

	// Update control and row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1   <= 1'b0;
			fwd_s1  <= 1'b0;
			valid_q <= '0;
		end else begin
			wr_s1  <= edge_req;
			fwd_s1 <= edge_req && wr_s1 && (row_s1 == edge_row);
			if (ctl.clear) begin
				valid_q <= '0;
			end else if (wr_s1) begin
				valid_q[row_s1] <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tc_seq.sv =====
// ----------------------------------------------------------------------------
// tc_seq: count sequencer
// Walks every row pair i<j, reads both rows, and when bit (i,j) is set adds
// the popcount of their common neighbours below the node count.
// ----------------------------------------------------------------------------
module tc_seq #(
	parameter int W  = 64,
	parameter int IW = 6,
	parameter int CW = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       count_req,
	input  logic [CW-1:0]              n_eff,
	input  logic [W-1:0]               row_i_data,
	input  logic [W-1:0]               row_j_data,
	output tc_pkg::tc_ctl_t            ctl,
	output logic [IW-1:0]              rd_i,
	output logic [IW-1:0]              rd_j,
	output logic                       busy,
	output logic                       done,
	output logic [tc_pkg::COUNT_W-1:0] total
);

	localparam int G = (W + 7) / 8;

	tc_pkg::tc_state_t state_q, state_d;

	logic [IW-1:0] i_q, j_q, j_s1;
	logic [CW-1:0] n_q;
	logic          v_s1, v_s2, v_s3;
	logic [3:0]    grp_s2 [G];
	logic [6:0]    sum_s3;
	logic [tc_pkg::COUNT_W-1:0] acc_q;
	logic          last_j, last_i;
	logic [W-1:0]  mask, common;
	logic [G*8-1:0] common_pad;
	logic [3:0]    grp_d [G];
	logic [6:0]    sum_d;
	logic [tc_pkg::COUNT_W:0] acc_sum;

	assign last_j = (CW'(j_q) == n_q - CW'(1));
	assign last_i = (CW'(i_q) == n_q - CW'(2));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tc_pkg::ST_IDLE: begin
				if (count_req) begin
					state_d = (n_eff >= CW'(3)) ? tc_pkg::ST_SCAN : tc_pkg::ST_DRAIN;
				end
			end
			tc_pkg::ST_SCAN: begin
				if (last_j && last_i) begin
					state_d = tc_pkg::ST_DRAIN;
				end
			end
			tc_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) begin
					state_d = tc_pkg::ST_DONE;
				end
			end
			tc_pkg::ST_DONE: state_d = tc_pkg::ST_IDLE;
			default:         state_d = tc_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctl.rd_en = (state_q == tc_pkg::ST_SCAN);
		ctl.clear = (state_q == tc_pkg::ST_DONE);
		busy      = (state_q != tc_pkg::ST_IDLE);
		done      = (state_q == tc_pkg::ST_DONE);
	end

	assign rd_i  = i_q;
	assign rd_j  = j_q;
	assign total = acc_q;

	// Mask common neighbours to nodes below the count, popcount per byte
	always_comb begin
		for (int k = 0; k < W; k++) begin
			mask[k] = (CW'(k) < n_q);
		end
		common     = row_i_data & row_j_data & mask;
		common_pad = '0;
		common_pad[W-1:0] = common;
		for (int g = 0; g < G; g++) begin
			grp_d[g] = '0;
			for (int b = 0; b < 8; b++) begin
				grp_d[g] = grp_d[g] + 4'(common_pad[g*8+b]);
			end
		end
	end

	// Add the byte counts
	always_comb begin
		sum_d = '0;
		for (int g = 0; g < G; g++) begin
			sum_d = sum_d + 7'(grp_s2[g]);
		end
	end

	assign acc_sum = {1'b0, acc_q} + (tc_pkg::COUNT_W + 1)'(sum_s3);

	// Pipeline payload
	always_ff @(posedge clk) begin
		j_s1   <= j_q;
		grp_s2 <= grp_d;
		sum_s3 <= sum_d;
	end

	// Sequencer state, pair indices and the saturating accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tc_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= ctl.rd_en;
			v_s2    <= v_s1 && row_i_data[j_s1];
			v_s3    <= v_s2;
			if (state_q == tc_pkg::ST_IDLE && count_req) begin
				i_q   <= '0;
				j_q   <= IW'(1);
				n_q   <= n_eff;
				acc_q <= '0;
			end else if (state_q == tc_pkg::ST_SCAN) begin
				if (last_j) begin
					i_q <= i_q + IW'(1);
					j_q <= i_q + IW'(2);
				end else begin
					j_q <= j_q + IW'(1);
				end
			end
			if (v_s3) begin
				acc_q <= acc_sum[tc_pkg::COUNT_W] ? tc_pkg::COUNT_MAX
					: acc_sum[tc_pkg::COUNT_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/triangle_counter.sv =====
// ----------------------------------------------------------------------------
// triangle_counter: brute-force triangle count over an adjacency matrix
// Edge requests load an undirected graph; a count request returns the number
// of triangles among the first node_count nodes and clears the graph.
// ----------------------------------------------------------------------------
// An edge request leaves busy low, so edges may be sent every cycle while no
// count is in progress: each is a read-modify-write on one memory row, with the last
// write forwarded when two requests hit the same row. A count request raises
// busy for a scan that reads one row pair per cycle through the memory's two
// read ports, skipped when node_count limited to the matrix size is below
// three, and for a drain that ends early when the last pairs read hold no
// edge. The result appears with done for exactly one cycle and cannot be held
// off; the matrix is cleared in that same cycle through per-row valid bits,
// with no clearing pass. node_count is written through cfg_valid/cfg_ready
// only while busy is low.
module triangle_counter #(
	parameter int MAX_NODES = tc_pkg::MAX_NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [tc_pkg::NODE_W-1:0]   node_a,
	input  logic [tc_pkg::NODE_W-1:0]   node_b,
	output logic                        done,
	output logic [tc_pkg::COUNT_W-1:0]  triangle_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tc_pkg::NCFG_W-1:0]   cfg_data
);

	// Rows beyond the reach of a six-bit endpoint never hold a bit
	localparam int STORE = (MAX_NODES < tc_pkg::ROW_LIMIT) ? MAX_NODES : tc_pkg::ROW_LIMIT;
	localparam int IW    = $clog2(STORE);
	localparam int CW    = $clog2(STORE + 1);

	logic [tc_pkg::NCFG_W-1:0] node_count_q;
	logic [CW-1:0]             n_eff;
	logic                      accept, in_range, edge_req, count_req;
	logic [tc_pkg::NODE_W-1:0] lo_node, hi_node;
	tc_pkg::tc_ctl_t           ctl;
	logic [IW-1:0]             rd_i, rd_j;
	logic [STORE-1:0]          row_i_data, row_j_data;

	// Take configuration only between counts
	assign cfg_ready = !busy;

	// Hold the node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= tc_pkg::NODE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// Limit the node count to the matrix size
	assign n_eff = (node_count_q > tc_pkg::NCFG_W'(STORE)) ? CW'(STORE)
		: CW'(node_count_q);

	// Decode the request; drop out-of-range edges and self-loops
	assign accept    = start && !busy;
	assign in_range  = ({1'b0, node_a} < tc_pkg::NCFG_W'(n_eff))
		&& ({1'b0, node_b} < tc_pkg::NCFG_W'(n_eff));
	assign edge_req  = accept && (operation == tc_pkg::OP_EDGE) && in_range
		&& (node_a != node_b);
	assign count_req = accept && (operation == tc_pkg::OP_COUNT);

	// Store each edge in the row of its lower endpoint
	assign lo_node = (node_a < node_b) ? node_a : node_b;
	assign hi_node = (node_a < node_b) ? node_b : node_a;

	tc_matrix #(
		.W  (STORE),
		.IW (IW)
	) u_matrix (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_req   (edge_req),
		.edge_row   (lo_node[IW-1:0]),
		.edge_col   (hi_node[IW-1:0]),
		.ctl        (ctl),
		.rd_i       (rd_i),
		.rd_j       (rd_j),
		.row_i_data (row_i_data),
		.row_j_data (row_j_data)
	);

	tc_seq #(
		.W  (STORE),
		.IW (IW),
		.CW (CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.count_req  (count_req),
		.n_eff      (n_eff),
		.row_i_data (row_i_data),
		.row_j_data (row_j_data),
		.ctl        (ctl),
		.rd_i       (rd_i),
		.rd_j       (rd_j),
		.busy       (busy),
		.done       (done),
		.total      (triangle_count)
	);

endmodule

// ===== rtl/tc_checker.sv =====
// ----------------------------------------------------------------------------
// tc_checker: port-level checks for the triangle counter
// Relates count requests, busy and the result strobe over time.
// ----------------------------------------------------------------------------
module tc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        operation,
	input logic                        done,
	input logic [tc_pkg::COUNT_W-1:0]  triangle_count
);

	// A count request starts a busy period
	a_count_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == tc_pkg::OP_COUNT) |=> busy)
		else $error("count request did not raise busy");

	// An edge request leaves the block free for the next request
	a_edge_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == tc_pkg::OP_EDGE) |=> !busy)
		else $error("edge request raised busy");

	// A result only comes at the end of a busy period
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy)
		else $error("result outside the end of a count");

	// The result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held");

	// No graph on the matrix can exceed the triple count of its rows
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (triangle_count <= 16'd41664))
		else $error("triangle count out of range");

endmodule

bind triangle_counter tc_checker u_tc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.operation      (operation),
	.done           (done),
	.triangle_count (triangle_count)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the triangle counter
// Loads small graphs through edge requests, asks for triangle counts and
// checks each count against a bit-matrix predictor kept in step with the
// accepted requests. Covers node_count settings from zero past the matrix
// size, out-of-range endpoints, self-loops and stale bits left by a
// shrinking node_count, with bursty request traffic.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES         = tc_pkg::MAX_NODES_DEF;
	localparam int SETTLE_CYCLES = 6;
	localparam int TAIL_CYCLES   = 16;
	localparam int RANDOM_ITEMS  = 400;
	localparam int RANDOM_COUNTS = 40;

	typedef enum logic [1:0] {
		JOB_REQ,
		JOB_CFG,
		JOB_SYNC
	} job_kind_t;

	typedef struct {
		job_kind_t                 kind;
		tc_pkg::op_t               op;
		logic [tc_pkg::NODE_W-1:0] a;
		logic [tc_pkg::NODE_W-1:0] b;
		logic [tc_pkg::NCFG_W-1:0] cfg;
		bit                        dense;
	} job_t;

	// DUT ports
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic                       operation = tc_pkg::OP_EDGE;
	logic [tc_pkg::NODE_W-1:0]  node_a = '0;
	logic [tc_pkg::NODE_W-1:0]  node_b = '0;
	logic                       done;
	logic [tc_pkg::COUNT_W-1:0] triangle_count;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [tc_pkg::NCFG_W-1:0]  cfg_data = '0;

	// Pending work and expected counts
	job_t                       jobs[$];
	logic [tc_pkg::COUNT_W-1:0] expected_counts[$];

	// Predictor state
	logic [NODES-1:0]          graph_rows [NODES];
	logic [tc_pkg::NCFG_W-1:0] node_limit = tc_pkg::NODE_COUNT_RST;

	// Driver state
	job_t shown;
	int   gap_left = 0;
	int   burst_left = 0;
	int   quiet_cycles = 0;

	// Statistics
	int mismatches = 0;
	int edge_reqs = 0;
	int count_reqs = 0;
	int cfg_writes = 0;
	int results_seen = 0;
	int largest_count = 0;

	triangle_counter i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.node_a         (node_a),
		.node_b         (node_b),
		.done           (done),
		.triangle_count (triangle_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Count triples i<j<k below lim whose three pair bits are set
	function automatic logic [tc_pkg::COUNT_W-1:0] tally_triangles(int unsigned lim);
		logic [NODES-1:0] in_use;
		logic [NODES-1:0] above;
		int unsigned      total;
		total = 0;
		in_use = (lim >= NODES) ? '1 : ((NODES'(1) << lim) - NODES'(1));
		for (int i = 0; i < lim; i++) begin
			for (int j = i + 1; j < lim; j++) begin
				if (graph_rows[i][j]) begin
					above = ~((NODES'(1) << (j + 1)) - NODES'(1));
					total += $countones(graph_rows[i] & graph_rows[j] & in_use & above);
				end
			end
		end
		return (total > tc_pkg::COUNT_MAX) ? tc_pkg::COUNT_MAX
			: total[tc_pkg::COUNT_W-1:0];
	endfunction

	// Apply one accepted request to the predicted graph
	function automatic void predict_request(job_t j);
		int unsigned lim;
		lim = (node_limit > NODES) ? NODES : node_limit;
		if (j.op == tc_pkg::OP_EDGE) begin
			if (j.a < lim && j.b < lim) begin
				graph_rows[j.a][j.b] = 1'b1;
				graph_rows[j.b][j.a] = 1'b1;
			end
			edge_reqs++;
		end else begin
			expected_counts.push_back(tally_triangles(lim));
			for (int r = 0; r < NODES; r++)
				graph_rows[r] = '0;
			count_reqs++;
		end
	endfunction

	// Drive requests and config writes from the job queue
	always @(posedge clk or negedge arst_n) begin : drive_requests
		job_t head;
		bit   hold_start;
		bit   hold_cfg;
		if (!arst_n) begin
			start      <= 1'b0;
			operation  <= tc_pkg::OP_EDGE;
			node_a     <= '0;
			node_b     <= '0;
			cfg_valid  <= 1'b0;
			cfg_data   <= '0;
			node_limit = tc_pkg::NODE_COUNT_RST;
			for (int r = 0; r < NODES; r++)
				graph_rows[r] = '0;
			gap_left     = 0;
			burst_left   = 0;
			quiet_cycles = 0;
		end else begin
			hold_start = start && busy;
			hold_cfg   = cfg_valid && !cfg_ready;

			// track accepted request and config write
			if (start && !busy)
				predict_request(shown);
			if (cfg_valid && cfg_ready) begin
				node_limit = cfg_data;
				cfg_writes++;
			end

			// count idle cycles with nothing outstanding
			if (!start && !cfg_valid && !busy && expected_counts.size() == 0)
				quiet_cycles++;
			else
				quiet_cycles = 0;

			// pick the next job once the current one is gone
			if (!hold_start && !hold_cfg && jobs.size() > 0) begin
				head = jobs[0];
				case (head.kind)
				JOB_REQ: begin
					if (gap_left > 0) begin
						gap_left--;
					end else begin
						head = jobs.pop_front();
						shown = head;
						operation  <= head.op;
						node_a     <= head.a;
						node_b     <= head.b;
						hold_start = 1'b1;
						if (burst_left > 0)
							burst_left--;
						if (burst_left == 0 && !head.dense) begin
							burst_left = $urandom_range(1, 12);
							gap_left   = $urandom_range(1, 6);
						end
					end
				end
				JOB_CFG: begin
					if (quiet_cycles >= SETTLE_CYCLES) begin
						head = jobs.pop_front();
						cfg_data <= head.cfg;
						hold_cfg = 1'b1;
					end
				end
				default: begin
					if (quiet_cycles >= SETTLE_CYCLES)
						head = jobs.pop_front();
				end
				endcase
			end

			start     <= hold_start;
			cfg_valid <= hold_cfg;
		end
	end

	// Check each count result against the oldest prediction
	always @(posedge clk) begin : check_results
		logic [tc_pkg::COUNT_W-1:0] want;
		if (arst_n && done) begin
			if (expected_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: triangle_count=%0d, none pending",
						$realtime, triangle_count);
			end else begin
				want = expected_counts.pop_front();
				results_seen++;
				if (triangle_count > largest_count)
					largest_count = triangle_count;
				if (triangle_count !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] triangle_count mismatch: expected %0d, got %0d",
							$realtime, want, triangle_count);
				end
			end
		end
	end

	task automatic queue_edge(int a, int b, bit dense = 1'b0);
		job_t j;
		j.kind  = JOB_REQ;
		j.op    = tc_pkg::OP_EDGE;
		j.a     = a[tc_pkg::NODE_W-1:0];
		j.b     = b[tc_pkg::NODE_W-1:0];
		j.cfg   = '0;
		j.dense = dense;
		jobs.push_back(j);
	endtask

	task automatic queue_count(bit dense = 1'b0);
		job_t j;
		j.kind  = JOB_REQ;
		j.op    = tc_pkg::OP_COUNT;
		j.a     = tc_pkg::NODE_W'($urandom);
		j.b     = tc_pkg::NODE_W'($urandom);
		j.cfg   = '0;
		j.dense = dense;
		jobs.push_back(j);
	endtask

	task automatic queue_cfg(int value);
		job_t j;
		j.kind  = JOB_CFG;
		j.op    = tc_pkg::OP_EDGE;
		j.a     = '0;
		j.b     = '0;
		j.cfg   = value[tc_pkg::NCFG_W-1:0];
		j.dense = 1'b0;
		jobs.push_back(j);
	endtask

	task automatic queue_sync();
		job_t j;
		j.kind  = JOB_SYNC;
		j.op    = tc_pkg::OP_EDGE;
		j.a     = '0;
		j.b     = '0;
		j.cfg   = '0;
		j.dense = 1'b0;
		jobs.push_back(j);
	endtask

	// Build the stimulus, then wait for the block to drain and report
	initial begin : run_test
		int gen_n;
		int eff;
		int span;
		int base;
		int pick;
		int graphs;
		int links;
		int big_left;
		int rand_items;
		int rand_counts;
		bit dense;

		// empty graph at reset size
		queue_count();
		// two triangles, one on the top nodes, plus self-loop and duplicate
		queue_edge(0, 1);
		queue_edge(1, 2);
		queue_edge(2, 0);
		queue_edge(63, 62);
		queue_edge(62, 61);
		queue_edge(61, 63);
		queue_edge(5, 5);
		queue_edge(1, 0);
		queue_count();
		// three nodes: endpoint at the limit is dropped
		queue_cfg(3);
		queue_edge(0, 1);
		queue_edge(1, 2);
		queue_edge(0, 2);
		queue_edge(0, 3);
		queue_edge(3, 3);
		queue_count();
		// fewer than three nodes
		queue_cfg(2);
		queue_edge(0, 1);
		queue_edge(1, 0);
		queue_count();
		queue_cfg(0);
		queue_edge(0, 0);
		queue_count();
		// stale bits from a larger node count, then the oversized setting
		queue_sync();
		queue_cfg(64);
		queue_edge(10, 11);
		queue_edge(11, 12);
		queue_edge(10, 12);
		queue_cfg(12);
		queue_count();
		queue_cfg(127);
		queue_count();
		gen_n = 127;

		// random phases: mostly small graphs with clustered endpoints
		big_left    = 5;
		rand_items  = 0;
		rand_counts = 0;
		while (rand_items < RANDOM_ITEMS || rand_counts < RANDOM_COUNTS) begin
			pick = $urandom_range(0, 19);
			if ($urandom_range(0, 4) != 0) begin
				if (pick < 13)
					gen_n = $urandom_range(3, 12);
				else if (pick < 15)
					gen_n = $urandom_range(13, 24);
				else if (pick < 17)
					gen_n = $urandom_range(0, 2);
				else if (big_left > 0) begin
					gen_n = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
					big_left--;
				end else
					gen_n = $urandom_range(3, 8);
				queue_cfg(gen_n);
			end
			eff = (gen_n > NODES) ? NODES : gen_n;
			dense = ($urandom_range(0, 3) == 0);
			graphs = $urandom_range(1, 3);
			for (int g = 0; g < graphs; g++) begin
				if (eff < 2) begin
					span = 1;
					base = 0;
				end else begin
					span = $urandom_range(2, (eff < 10) ? eff : 10);
					base = $urandom_range(0, eff - span);
				end
				links = $urandom_range(0, 16);
				for (int e = 0; e < links; e++) begin
					if ($urandom_range(0, 9) == 0) begin
						queue_edge($urandom_range(0, 63), $urandom_range(0, 63), dense);
					end else begin
						queue_edge(base + $urandom_range(0, span - 1),
							base + $urandom_range(0, span - 1), dense);
						rand_items++;
					end
				end
				// leave the last graph loaded now and then
				if (g != graphs - 1 || $urandom_range(0, 7) != 0) begin
					queue_count(dense);
					rand_items++;
					rand_counts++;
				end
			end
			if ($urandom_range(0, 3) == 0)
				queue_sync();
		end

		// wait for the job queue and all results to drain
		do
			@(negedge clk);
		while (jobs.size() != 0 || start || cfg_valid || busy || expected_counts.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d edge requests, %0d count requests, %0d node_count writes.",
			edge_reqs, count_reqs, cfg_writes);
		$display("Checked %0d counts (largest %0d), %0d mismatches.",
			results_seen, largest_count, mismatches);
		if (mismatches == 0 && expected_counts.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Stop a hung run
	initial begin : watchdog
		#5_000_000;
		$display("Timeout: run did not drain, %0d counts still pending.",
			expected_counts.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
